// File: src/mbe_pkg.sv
// ============================================================================
// mbe_pkg : shared definitions for the masked border erosion unit
// Field widths, register codes, reset values and the result record.
// ============================================================================
`default_nettype none

package mbe_pkg;

    // default geometry limits
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    // configuration register widths and reset values
    localparam int LW_W       = 12;
    localparam int FH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam logic [LW_W-1:0] LW_RESET = LW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // payload field widths
    localparam int VAL_W       = 16;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 11;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;
    localparam int M_PAYLOAD_W = ROW_W + COL_W + VAL_W;

    // line buffer word: {value one row up, flag one row up, flag two rows up}
    localparam int LB_W = VAL_W + 2;

    // one emitted pixel
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             last;
        logic             fend;
    } t_result;

endpackage

`default_nettype wire

// File: src/mbe_line_buf.sv
// ============================================================================
// mbe_line_buf : dual-port line buffer with write-to-read forwarding
// One write and one read per cycle, registered read data held between reads.
// ============================================================================
`default_nettype none

module mbe_line_buf #(
    parameter int DEPTH = mbe_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                      i_clk,
    input  wire                      i_rd_en,
    input  wire  [AW-1:0]            i_rd_addr,
    output logic [mbe_pkg::LB_W-1:0] o_rd_data,
    input  wire                      i_wr_en,
    input  wire  [AW-1:0]            i_wr_addr,
    input  wire  [mbe_pkg::LB_W-1:0] i_wr_data
);
    import mbe_pkg::*;

    logic [LB_W-1:0] r_mem [DEPTH];
    logic [LB_W-1:0] r_rd;
    logic            r_byp;
    logic [LB_W-1:0] r_byp_data;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // same-cycle write to the entry being read: take the new word
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_byp_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd;

endmodule

`default_nettype wire

// File: src/masked_border_erosion_unit.sv
// ============================================================================
// masked_border_erosion_unit : streaming 3x3 erosion under an invalid mask
// Raster-order pixels in, border pixels passed through, interior pixels
// zeroed when any neighbor is flagged invalid.
// ============================================================================
// A pixel is taken every clock unless the input stage stalls. Each pixel
// gives zero, one or two results, and the single output channel moves one
// result per clock while the receiver is ready. Pixels that give two results
// are those of the last row from column two on and those of the last column
// from row two on. Such a pixel holds the input until the output queue has
// room for both results. Other pixels stream at one per clock while the
// queue has room. The earlier rows live in one line buffer memory of MAX_WIDTH
// words, read when a pixel is taken and written back when it leaves the input
// stage; a read of the entry written in the same cycle is forwarded. The
// memory is not cleared after reset and needs no start-up time.
`default_nettype none

module masked_border_erosion_unit #(
    parameter int MAX_WIDTH  = mbe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mbe_pkg::DEF_MAX_HEIGHT
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration write port
    input  wire                                i_cfg_we,
    input  wire  [mbe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [mbe_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // pixel input
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [mbe_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [15:0] blend_value
    input  wire                                s_axis_tuser,  // [0] texel_invalid
    // result output
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [11:0] out_row, [22:12] out_column, [38:23] out_value, [39] zero
    output logic [mbe_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast,  // last_of_run
    output logic                               m_axis_tuser   // [0] frame_end
);
    import mbe_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // configuration registers
    logic [LW_W-1:0] r_line_width;
    logic [FH_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LW_RESET;
            r_frame_height <= FH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[LW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // last column and last row of the clamped frame
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;

    always_comb begin
        if (r_line_width == '0) begin
            w_last = '0;
        end else if (32'(r_line_width) > 32'(MAX_WIDTH)) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(r_line_width - LW_W'(1));
        end
        if (r_frame_height == '0) begin
            h_last = '0;
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(r_frame_height - FH_W'(1));
        end
    end

    // raster counters and input stage
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic             r_s1_valid;
    logic             r_s1_flag;
    logic [VAL_W-1:0] r_s1_value;
    logic [CW-1:0]    r_s1_col;
    logic [RW-1:0]    r_s1_row;
    logic             r_s1_int;
    logic             r_s1_bdr;
    logic             r_s1_fend;

    logic s_accept;
    logic s1_fire;
    logic last_col;
    logic last_row;
    logic is_int;
    logic is_bdr;

    assign last_col = (r_col >= w_last);
    assign last_row = (r_row >= h_last);
    assign is_int   = (r_row >= RW'(2)) && (r_col >= CW'(2))
                      && (r_row <= h_last) && (r_col <= w_last);
    assign is_bdr   = (r_row == '0) || last_row || (r_col == '0) || last_col;

    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_s1_valid <= 1'b1;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_flag  <= s_axis_tuser;
            r_s1_value <= s_axis_tdata[VAL_W-1:0];
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
            r_s1_int   <= is_int;
            r_s1_bdr   <= is_bdr;
            r_s1_fend  <= last_row && last_col;
        end
    end

    // line buffer: read on accept, write back when the pixel is processed
    logic [LB_W-1:0] lb_rd;
    logic [LB_W-1:0] lb_wr;
    logic            up1;
    logic            up2;
    logic [VAL_W-1:0] up_value;

    assign up_value = lb_rd[LB_W-1:2];
    assign up1      = lb_rd[1];
    assign up2      = lb_rd[0];
    assign lb_wr    = {r_s1_value, r_s1_flag, up1};

    mbe_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (s_accept),
        .i_rd_addr (r_col),
        .o_rd_data (lb_rd),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_col),
        .i_wr_data (lb_wr)
    );

    // 3x3 flag window and held center value
    logic [8:0]       r_window;
    logic [VAL_W-1:0] r_center;
    logic [8:0]       n_window;

    assign n_window = {r_window[5:0], up2, up1, r_s1_flag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_center <= '0;
        end else if (s1_fire) begin
            r_window <= n_window;
            r_center <= up_value;
        end
    end

    // results of the pixel in the input stage
    t_result res_int;
    t_result res_bdr;

    always_comb begin
        res_int.row   = ROW_W'(r_s1_row - RW'(1));
        res_int.col   = COL_W'(r_s1_col - CW'(1));
        res_int.value = (n_window != '0) ? '0 : r_center;
        res_int.last  = !r_s1_bdr;
        res_int.fend  = 1'b0;
        res_bdr.row   = ROW_W'(r_s1_row);
        res_bdr.col   = COL_W'(r_s1_col);
        res_bdr.value = r_s1_value;
        res_bdr.last  = 1'b1;
        res_bdr.fend  = r_s1_fend;
    end

    // two-entry output queue; slot 0 faces the output port
    logic [1:0] r_cnt;
    t_result    r_slot0;
    t_result    r_slot1;
    logic [1:0] n_cnt;
    t_result    n_slot0;
    t_result    n_slot1;
    logic       m_pop;
    logic [1:0] post_cnt;
    logic [1:0] push_n;
    t_result    first_res;

    assign m_pop     = m_axis_tvalid && m_axis_tready;
    assign post_cnt  = r_cnt - {1'b0, m_pop};
    assign push_n    = {1'b0, r_s1_int} + {1'b0, r_s1_bdr};
    assign s1_fire   = r_s1_valid && (({1'b0, post_cnt} + {1'b0, push_n}) <= 3'd2);
    assign first_res = r_s1_int ? res_int : res_bdr;

    always_comb begin
        n_slot0 = m_pop ? r_slot1 : r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = post_cnt;
        if (s1_fire) begin
            n_cnt = post_cnt + push_n;
            if (push_n != 2'd0) begin
                if (post_cnt == 2'd0) begin
                    n_slot0 = first_res;
                    if (push_n == 2'd2) begin
                        n_slot1 = res_bdr;
                    end
                end else begin
                    n_slot1 = first_res;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    // output port
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {(M_TDATA_W - M_PAYLOAD_W)'(0),
                            r_slot0.value, r_slot0.col, r_slot0.row};
    assign m_axis_tlast  = r_slot0.last;
    assign m_axis_tuser  = r_slot0.fend;

endmodule

`default_nettype wire

// File: test/masked_border_erosion_unit_test.sv
// ============================================================================
// masked_border_erosion_unit_test : self-checking bench for the erosion unit
// Streams raster-order pixels, predicts every emitted pixel with a behavioral
// line-buffer model and checks each output transaction in order. Covers the
// reset geometry, clamped and degenerate frame sizes, mid-frame resizing,
// and random frames under random input gaps and output back-pressure.
// ============================================================================

module masked_border_erosion_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mbe_pkg::*;

    localparam int PHASE_PIXELS = 280;

    // ------------------------------------------------------------------------
    // Expected-pixel store and line-buffer predictor
    // ------------------------------------------------------------------------
    class erosion_scoreboard;
        logic [LW_W-1:0]  line_width;
        logic [FH_W-1:0]  frame_height;
        bit               flags_up1 [DEF_MAX_WIDTH];
        bit               flags_up2 [DEF_MAX_WIDTH];
        logic [VAL_W-1:0] values_up1 [DEF_MAX_WIDTH];
        bit   [8:0]       window;
        logic [VAL_W-1:0] center_hold;
        int unsigned      column;
        int unsigned      row;
        t_result          expected_q [$];
        int               mismatches;
        int               pixels;
        int               results;
        int               frames;
        int               eroded;

        function new();
            line_width   = LW_RESET;
            frame_height = FH_RESET;
            foreach (flags_up1[i]) begin
                flags_up1[i]  = 1'b0;
                flags_up2[i]  = 1'b0;
                values_up1[i] = '0;
            end
            window      = '0;
            center_hold = '0;
            column      = 0;
            row         = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LINE_WIDTH:   line_width   = data[LW_W-1:0];
                CFG_FRAME_HEIGHT: frame_height = data[FH_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function bit at_frame_start();
            return column == 0 && row == 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // one accepted input pixel: update line buffers, queue what it emits
        function void note_pixel(bit flag, logic [VAL_W-1:0] value);
            int unsigned      w;
            int unsigned      h;
            int unsigned      c;
            int unsigned      r;
            bit               up1;
            bit               up2;
            bit               last_col;
            bit               last_row;
            logic [VAL_W-1:0] center;
            t_result          res;
            int               n0;

            w = clamp_dim(line_width, DEF_MAX_WIDTH);
            h = clamp_dim(frame_height, DEF_MAX_HEIGHT);
            c = column;
            r = row;
            up1 = flags_up1[c];
            up2 = flags_up2[c];
            center   = center_hold;
            last_col = (c >= w - 1);
            last_row = (r >= h - 1);

            // newest window column enters in the low bits
            window        = {window[5:0], up2, up1, flag};
            center_hold   = values_up1[c];
            values_up1[c] = value;
            flags_up2[c]  = up1;
            flags_up1[c]  = flag;

            n0 = expected_q.size();
            // interior pixel up and to the left
            if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1) begin
                res.row   = ROW_W'(r - 1);
                res.col   = COL_W'(c - 1);
                res.value = (window != 0) ? '0 : center;
                res.last  = 1'b0;
                res.fend  = 1'b0;
                if (window != 0) eroded++;
                expected_q.push_back(res);
            end
            // border pixel goes straight through
            if (r == 0 || last_row || c == 0 || last_col) begin
                res.row   = ROW_W'(r);
                res.col   = COL_W'(c);
                res.value = value;
                res.last  = 1'b0;
                res.fend  = last_row && last_col;
                expected_q.push_back(res);
            end
            if (expected_q.size() > n0) begin
                res = expected_q.pop_back();
                res.last = 1'b1;
                expected_q.push_back(res);
            end

            // raster counters
            if (last_col) begin
                column = 0;
                row    = last_row ? 0 : r + 1;
            end else begin
                column = c + 1;
            end
            pixels++;
        endfunction

        // one accepted output transaction against the oldest expectation
        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result row %0d col %0d value %h last %b fend %b",
                         $time, got.row, got.col, got.value, got.last, got.fend);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.row !== want.row || got.col !== want.col || got.value !== want.value ||
                got.last !== want.last || got.fend !== want.fend) begin
                $display("%0t: mismatch expected row %0d col %0d value %h last %b fend %b",
                         $time, want.row, want.col, want.value, want.last, want.fend);
                $display("%0t:          actual   row %0d col %0d value %h last %b fend %b",
                         $time, got.row, got.col, got.value, got.last, got.fend);
                mismatches++;
            end
            results++;
            if (want.fend) frames++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data     = '0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata   = '0;  // [15:0] blend_value
    logic                   s_axis_tuser   = 1'b0; // [0] texel_invalid
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    // [11:0] out_row, [22:12] out_column, [38:23] out_value, [39] zero
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tlast;   // last_of_run
    logic                   m_axis_tuser;   // [0] frame_end

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mid_changes        = 0;

    erosion_scoreboard sb = new();

    masked_border_erosion_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // output back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // output monitor
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.row   = m_axis_tdata[ROW_W-1:0];
            got.col   = m_axis_tdata[ROW_W+COL_W-1:ROW_W];
            got.value = m_axis_tdata[M_PAYLOAD_W-1:ROW_W+COL_W];
            got.last  = m_axis_tlast;
            got.fend  = m_axis_tuser;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // one pixel transaction, with random gaps ahead of it
    task automatic send_pixel(bit flag, logic [VAL_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= flag;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_pixel(flag, value);
    endtask

    task automatic send_random(int flag_pct);
        logic [VAL_W-1:0] value;
        case ($urandom_range(9))
            0:       value = '0;
            1:       value = '1;
            default: value = VAL_W'($urandom);
        endcase
        send_pixel($urandom_range(99) < flag_pct, value);
    endtask

    // pixels until the raster counters wrap back to the frame origin
    task automatic send_frame(int flag_pct);
        do send_random(flag_pct); while (!sb.at_frame_start());
    endtask

    // stop sending and wait out every outstanding pixel; ends on a falling edge
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // called on a falling edge while the block is idle; ends on a falling edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int width;
        int height;
        int area;
        int flag_pct;
        int phase_start;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry (640 x 480): first row pixels are border, value extremes
        send_pixel(1'b0, 16'hFFFF);
        send_pixel(1'b0, 16'h0000);
        send_pixel(1'b0, 16'h8000);
        send_pixel(1'b0, 16'h0001);
        send_pixel(1'b1, 16'h7FFF);
        send_pixel(1'b1, 16'hFFFE);
        drain();

        // shrink mid-frame: column 6 is past the new last column, next pixel ends the row
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(4));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(3));
        mid_changes++;
        send_pixel(1'b1, 16'h1234);
        // interior (1,1) keeps its value, (1,2) is eroded by the flag at (2,3)
        send_pixel(1'b0, 16'hAAAA);
        send_pixel(1'b0, 16'h5555);
        send_pixel(1'b0, 16'h3C3C);
        send_pixel(1'b0, 16'h0F0F);
        send_pixel(1'b0, 16'hF0F0);
        send_pixel(1'b0, 16'h00FF);
        send_pixel(1'b0, 16'hFF00);
        send_pixel(1'b1, 16'hFFFF);
        drain();

        // zero clamps to one: every pixel is a whole frame
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(0));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(0));
        send_pixel(1'b1, 16'hFFFF);
        send_pixel(1'b0, 16'h0000);
        drain();

        // bit 12 of the data port is dropped for line_width: 2 x 2 frame
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(13'h1002));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(2));
        send_pixel(1'b0, 16'h8001);
        send_pixel(1'b1, 16'h4002);
        send_pixel(1'b1, 16'h2004);
        send_pixel(1'b0, 16'h1008);
        drain();

        // oversize geometry clamps to the limits: a short run along row zero
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(4095));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(13'h1FFF));
        repeat (8) send_random(30);
        drain();

        // finish as a 12 x 2 frame: fills every line buffer entry the random frames use
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(12));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(2));
        mid_changes++;
        send_frame(30);

        // random frames under four idling mixes
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct    = (p == 1) ? 66 : (p == 3) ? 12 : 0;
            receiver_stall_pct = (p == 2) ? 66 : (p == 3) ? 12 : 0;
            phase_start = sb.pixels;
            while (sb.pixels - phase_start < PHASE_PIXELS) begin
                drain();
                width  = ($urandom_range(5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
                height = ($urandom_range(5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
                write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(width));
                write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(height));
                case ($urandom_range(3))
                    0:       flag_pct = 0;
                    1:       flag_pct = 5;
                    2:       flag_pct = 20;
                    default: flag_pct = 60;
                endcase
                area = (width == 0 ? 1 : width) * (height == 0 ? 1 : height);
                // resize part way through some frames
                if (area > 1 && $urandom_range(4) == 0) begin
                    repeat ($urandom_range(1, area - 1)) send_random(flag_pct);
                    drain();
                    if ($urandom_range(1))
                        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'($urandom_range(1, 12)));
                    else
                        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(1, 8)));
                    mid_changes++;
                end
                send_frame(flag_pct);
            end
        end

        drain();
        repeat (10) @(negedge i_clk);

        $display("Covered %0d pixels and %0d output transactions over %0d frames,",
                 sb.pixels, sb.results, sb.frames);
        $display("%0d eroded interior pixels and %0d mid-frame resizes.",
                 sb.eroded, mid_changes);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
